>>> rtl/core/erax_pkg.sv
// Shared types and constants for the extended rotate and address ALU.
package erax_pkg;

    localparam int unsigned DATA_W  = 20;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned COUNT_W = 3;

    localparam logic [DATA_W-1:0] MASK_WORD = 20'h0FFFF;
    localparam logic [DATA_W-1:0] MASK_ADDR = 20'hFFFFF;
    localparam int unsigned       TOP_WORD  = 15;
    localparam int unsigned       TOP_ADDR  = 19;

    typedef enum logic [OP_W-1:0] {
        OP_RRUM = 3'd0,
        OP_RRCM = 3'd1,
        OP_RRAM = 3'd2,
        OP_RLAM = 3'd3,
        OP_ADD  = 3'd4,
        OP_SUB  = 3'd5
    } opcode_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

endpackage

>>> rtl/core/erax_exec.sv
// Combinational execute logic: shifts, rotates, add and subtract with flag update.
module erax_exec (
    input  logic [2:0]           opcode,
    input  logic [19:0]          source_value,
    input  logic [19:0]          dest_value,
    input  logic [2:0]           shift_count,
    input  logic                 address_word,
    input  erax_pkg::flags_t     flags_in,
    output logic [19:0]          result,
    output erax_pkg::flags_t     flags_out
);

    logic [19:0] mask;
    logic [19:0] s_m;
    logic [19:0] d_m;
    logic [1:0]  steps_m1;
    logic [20:0] sum;
    logic [20:0] diff;
    logic [19:0] r_sh;
    logic        c_sh;
    logic [19:0] r_out;

    assign mask     = address_word ? erax_pkg::MASK_ADDR : erax_pkg::MASK_WORD;
    assign s_m      = source_value & mask;
    assign d_m      = dest_value & mask;
    assign steps_m1 = 2'(shift_count - 3'd1);
    assign sum      = {1'b0, d_m} + {1'b0, s_m};
    assign diff     = {1'b0, d_m} + {1'b0, ~s_m & mask} + 21'd1;

    // Unroll up to four single-bit steps of the selected shift
    always_comb
    begin
        logic [19:0] r;
        logic        c;
        logic        fill;
        logic        lsb;
        r    = d_m;
        c    = flags_in.c;
        fill = 1'b0;
        lsb  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) <= steps_m1)
            begin
                if (opcode == erax_pkg::OP_RLAM)
                begin
                    c = address_word ? r[erax_pkg::TOP_ADDR] : r[erax_pkg::TOP_WORD];
                    r = {r[18:0], 1'b0} & mask;
                end
                else
                begin
                    lsb = r[0];
                    case (opcode)
                        erax_pkg::OP_RRCM: fill = c;
                        erax_pkg::OP_RRAM: fill = address_word ? r[erax_pkg::TOP_ADDR]
                                                               : r[erax_pkg::TOP_WORD];
                        default:           fill = 1'b0;
                    endcase
                    r = {1'b0, r[19:1]};
                    if (address_word)
                    begin
                        r[erax_pkg::TOP_ADDR] = fill;
                    end
                    else
                    begin
                        r[erax_pkg::TOP_WORD] = fill;
                        r[19:16]              = 4'd0;
                    end
                    c = lsb;
                end
            end
        end
        r_sh = r;
        c_sh = c;
    end

    // Select the result and update the flags
    always_comb
    begin
        logic [19:0] ovf_vec;
        ovf_vec   = '0;
        r_out     = d_m;
        flags_out = flags_in;
        case (opcode)
            erax_pkg::OP_RRUM,
            erax_pkg::OP_RRCM,
            erax_pkg::OP_RRAM:
            begin
                r_out       = r_sh;
                flags_out.c = c_sh;
                flags_out.v = 1'b0;
            end
            erax_pkg::OP_RLAM:
            begin
                r_out       = r_sh;
                flags_out.c = c_sh;
            end
            erax_pkg::OP_ADD:
            begin
                r_out       = sum[19:0] & mask;
                flags_out.c = address_word ? sum[20] : sum[16];
                ovf_vec     = ~(s_m ^ d_m) & (d_m ^ r_out);
                flags_out.v = address_word ? ovf_vec[erax_pkg::TOP_ADDR]
                                           : ovf_vec[erax_pkg::TOP_WORD];
            end
            erax_pkg::OP_SUB:
            begin
                r_out       = diff[19:0] & mask;
                flags_out.c = address_word ? diff[20] : diff[16];
                ovf_vec     = (s_m ^ d_m) & (d_m ^ r_out);
                flags_out.v = address_word ? ovf_vec[erax_pkg::TOP_ADDR]
                                           : ovf_vec[erax_pkg::TOP_WORD];
            end
            default:
            begin
                r_out     = d_m;
                flags_out = flags_in;
            end
        endcase
        if (opcode <= erax_pkg::OP_SUB)
        begin
            flags_out.n = address_word ? r_out[erax_pkg::TOP_ADDR] : r_out[erax_pkg::TOP_WORD];
            flags_out.z = (r_out == 20'd0);
        end
    end

    assign result = r_out;

endmodule

>>> rtl/core/extended_rotate_and_address_alu.sv
// Each beat passes through two registers: the input register, then the result register.
// Throughput: one beat per cycle while out_ready keeps the result register draining.
// Flags are registered with each result, so every beat sees the flags left by the previous one.
// Reset (rst_n low, asynchronous) empties both registers and clears N, Z, C and V.
// The input side keeps accepting while a result waits, as long as the result register drains.
module extended_rotate_and_address_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [19:0] source_value,
    input  logic [19:0] dest_value,
    input  logic [2:0]  shift_count,
    input  logic        address_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [19:0] result,
    output logic        negative,
    output logic        zero,
    output logic        carry,
    output logic        overflow
);

    logic              s1_valid_reg;
    logic [2:0]        op_reg;
    logic [19:0]       src_reg;
    logic [19:0]       dst_reg;
    logic [2:0]        cnt_reg;
    logic              aw_reg;
    logic              out_valid_reg;
    logic [19:0]       result_reg;
    erax_pkg::flags_t  flags_reg;
    erax_pkg::flags_t  flags_next;
    logic [19:0]       result_next;
    logic              s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Hold the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode;
            src_reg <= source_value;
            dst_reg <= dest_value;
            cnt_reg <= shift_count;
            aw_reg  <= address_word;
        end
    end

    erax_exec u_exec (
        .opcode       (op_reg),
        .source_value (src_reg),
        .dest_value   (dst_reg),
        .shift_count  (cnt_reg),
        .address_word (aw_reg),
        .flags_in     (flags_reg),
        .result       (result_next),
        .flags_out    (flags_next)
    );

    // Advance into the result register and commit the flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign negative  = flags_reg.n;
    assign zero      = flags_reg.z;
    assign carry     = flags_reg.c;
    assign overflow  = flags_reg.v;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced beat did not reach result register");

    a_word_mode_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !aw_reg) |=> (result_reg[19:16] == 4'd0))
        else $error("word mode result has upper bits set");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (op_reg <= erax_pkg::OP_SUB)) |=> (flags_reg.z == (result_reg == 20'd0)))
        else $error("Z flag disagrees with result");
`endif

endmodule

>>> test/erax_alu_checker.sv
// Checker for the extended ALU: flag-tracking predictor and in-order result comparison.
module erax_alu_checker
    import erax_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [DATA_W-1:0] source_value,
    input  logic [DATA_W-1:0] dest_value,
    input  logic [COUNT_W-1:0] shift_count,
    input  logic              address_word,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DATA_W-1:0] result,
    input  logic              negative,
    input  logic              zero,
    input  logic              carry,
    input  logic              overflow,
    output int                mismatches,
    output int                pending,
    output int                results_seen
);

    typedef struct packed {
        logic [DATA_W-1:0] result;
        flags_t            flags;
    } alu_beat_t;

    // Results owed by the block, oldest first
    alu_beat_t expected_beats[$];
    // Flags as the block should hold them after the last accepted beat
    flags_t    status;
    int        reported;

    // Execute one instruction on the given flags; return the result and the new flags
    function automatic alu_beat_t alu_execute(
        input logic [OP_W-1:0]    op,
        input logic [DATA_W-1:0]  src,
        input logic [DATA_W-1:0]  dst,
        input logic [COUNT_W-1:0] count,
        input logic               wide,
        input flags_t             now
    );
        logic [DATA_W-1:0]  mask;
        logic [DATA_W-1:0]  s;
        logic [DATA_W-1:0]  d;
        logic [DATA_W-1:0]  r;
        logic [DATA_W-1:0]  sign_bits;
        logic [DATA_W:0]    sum;
        logic [COUNT_W-1:0] less_one;
        int unsigned        top;
        int unsigned        steps;
        logic               fill;
        logic               spill;
        logic               alu_op;
        alu_beat_t          beat;
        mask   = wide ? MASK_ADDR : MASK_WORD;
        top    = wide ? TOP_ADDR : TOP_WORD;
        s      = src & mask;
        d      = dst & mask;
        r      = d;
        // Only the low two bits of count minus one matter, so 0 behaves as 4
        less_one = count - 1'b1;
        steps  = less_one[1:0] + 1;
        beat.flags = now;
        alu_op = 1'b1;
        case (op)
            OP_RRUM, OP_RRCM, OP_RRAM:
            begin
                for (int i = 0; i < steps; i++)
                begin
                    spill = r[0];
                    if (op == OP_RRUM)
                        fill = 1'b0;
                    else if (op == OP_RRCM)
                        fill = beat.flags.c;
                    else
                        fill = r[top];
                    r = (r >> 1) & mask;
                    r[top] = fill;
                    beat.flags.c = spill;
                end
                beat.flags.v = 1'b0;
            end
            OP_RLAM:
            begin
                // V is left alone by the left shift
                for (int i = 0; i < steps; i++)
                begin
                    beat.flags.c = r[top];
                    r = (r << 1) & mask;
                end
            end
            OP_ADD:
            begin
                sum = {1'b0, s} + {1'b0, d};
                r = sum[DATA_W-1:0] & mask;
                beat.flags.c = sum[top+1];
                sign_bits = ~(s ^ d) & (d ^ r);
                beat.flags.v = sign_bits[top];
            end
            OP_SUB:
            begin
                // d + ~s + 1, carry set when no borrow
                sum = {1'b0, d} + {1'b0, (~s) & mask} + 1'b1;
                r = sum[DATA_W-1:0] & mask;
                beat.flags.c = sum[top+1];
                sign_bits = (s ^ d) & (d ^ r);
                beat.flags.v = sign_bits[top];
            end
            default:
            begin
                // Spare codes: pass the masked destination, keep every flag
                alu_op = 1'b0;
            end
        endcase
        if (alu_op)
        begin
            beat.flags.n = r[top];
            beat.flags.z = (r == '0);
        end
        beat.result = r;
        return beat;
    endfunction

    // Predict on each input beat, compare on each result beat
    always @(posedge clk or negedge rst_n)
    begin : watch
        alu_beat_t want;
        alu_beat_t got;
        if (!rst_n)
        begin
            expected_beats.delete();
            status       = '0;
            mismatches   = 0;
            reported     = 0;
            results_seen = 0;
            pending      <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                want = alu_execute(opcode, source_value, dest_value, shift_count,
                                   address_word, status);
                status = want.flags;
                expected_beats.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                got.result  = result;
                got.flags.n = negative;
                got.flags.z = zero;
                got.flags.c = carry;
                got.flags.v = overflow;
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("checker: result beat with nothing expected: %05h nzcv=%b",
                                 got.result, got.flags);
                    end
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got.result !== want.result || got.flags.n !== want.flags.n ||
                        got.flags.z !== want.flags.z || got.flags.c !== want.flags.c ||
                        got.flags.v !== want.flags.v)
                    begin
                        mismatches++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("checker: beat %0d expected %05h nzcv=%b, got %05h nzcv=%b",
                                     results_seen, want.result, want.flags,
                                     got.result, got.flags);
                        end
                    end
                end
            end
            pending <= expected_beats.size();
        end
    end

endmodule

>>> test/tb_top.sv
// Testbench top for the extended ALU: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
    import erax_pkg::*;

    // Spare opcodes that the block treats as no operation
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int PHASE_BEATS = 330;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;

    localparam int PH_FREE     = 0;
    localparam int PH_TX_IDLE  = 1;
    localparam int PH_RX_STALL = 2;
    localparam int PH_BOTH     = 3;
    localparam int PH_PRESSURE = 4;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    opcode = '0;
    logic [DATA_W-1:0]  source_value = '0;
    logic [DATA_W-1:0]  dest_value = '0;
    logic [COUNT_W-1:0] shift_count = '0;
    logic               address_word = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DATA_W-1:0]  result;
    logic               negative;
    logic               zero;
    logic               carry;
    logic               overflow;

    int mismatches;
    int pending;
    int results_seen;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic rx_hold_go = 1'b0;
    int hold_left = 0;
    logic hold_taken = 1'b0;
    int cycle_count = 0;

    int n_shift = 0;
    int n_arith = 0;
    int n_spare = 0;
    int n_wide = 0;

    always #5 clk = ~clk;

    extended_rotate_and_address_alu u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .source_value (source_value),
        .dest_value   (dest_value),
        .shift_count  (shift_count),
        .address_word (address_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result       (result),
        .negative     (negative),
        .zero         (zero),
        .carry        (carry),
        .overflow     (overflow)
    );

    erax_alu_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .source_value (source_value),
        .dest_value   (dest_value),
        .shift_count  (shift_count),
        .address_word (address_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result       (result),
        .negative     (negative),
        .zero         (zero),
        .carry        (carry),
        .overflow     (overflow),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Drive out_ready: one long hold-off when asked, otherwise random stalls
    always @(negedge clk)
    begin : receiver
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (rx_hold_go && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Bound the run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offer one beat, idling first at the sender's rate; return at the falling edge after acceptance
    task automatic send_beat(
        input logic [OP_W-1:0]    op,
        input logic [DATA_W-1:0]  src,
        input logic [DATA_W-1:0]  dst,
        input logic [COUNT_W-1:0] count,
        input logic               wide
    );
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        source_value <= src;
        dest_value   <= dst;
        shift_count  <= count;
        address_word <= wide;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (op <= OP_RLAM)
            n_shift++;
        else if (op <= OP_SUB)
            n_arith++;
        else
            n_spare++;
        if (wide)
            n_wide++;
    endtask

    // Operand biased toward sign and carry boundaries
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [3:0] upper;
        upper = 4'($urandom);
        case ($urandom_range(0, 9))
            0: return 20'h00000;
            1: return 20'hFFFFF;
            2: return 20'h7FFFF;
            3: return 20'h80000;
            4: return {upper, 16'h7FFF};
            5: return {upper, 16'h8000};
            6: return {upper, 16'hFFFF};
            default: return 20'($urandom);
        endcase
    endfunction

    // Random beat: mostly real operations and counts 1 to 4, a few spare codes and wrapped counts
    task automatic send_random_beat();
        logic [OP_W-1:0]    op;
        logic [DATA_W-1:0]  src;
        logic [DATA_W-1:0]  dst;
        logic [COUNT_W-1:0] count;
        if ($urandom_range(0, 99) < 6)
            op = ($urandom_range(0, 1) != 0) ? OP_SPARE7 : OP_SPARE6;
        else
            op = 3'($urandom_range(OP_RRUM, OP_SUB));
        if ($urandom_range(0, 99) < 15)
            count = 3'($urandom);
        else
            count = 3'($urandom_range(1, 4));
        src = pick_operand();
        dst = ($urandom_range(0, 9) == 0) ? src : pick_operand();
        send_beat(op, src, dst, count, 1'($urandom));
    endtask

    initial
    begin : stimulus
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: each operation, both widths, flag corners and odd codes
        send_beat(OP_RRUM, 20'h00000, 20'hFFFFF, 3'd1, 1'b0);
        send_beat(OP_RRUM, 20'h00000, 20'hFFFFF, 3'd4, 1'b1);
        send_beat(OP_RRCM, 20'h00000, 20'h00001, 3'd1, 1'b1);
        send_beat(OP_RRCM, 20'h00000, 20'h00000, 3'd4, 1'b0);
        send_beat(OP_RRAM, 20'h00000, 20'h80000, 3'd3, 1'b1);
        send_beat(OP_RRAM, 20'h00000, 20'hF8000, 3'd2, 1'b0);
        send_beat(OP_RLAM, 20'h00000, 20'hFFFFF, 3'd4, 1'b1);
        send_beat(OP_RLAM, 20'h00000, 20'h0C000, 3'd1, 1'b0);
        send_beat(OP_ADD,  20'h00001, 20'h07FFF, 3'd1, 1'b0);
        send_beat(OP_ADD,  20'hFFFFF, 20'h00001, 3'd1, 1'b1);
        send_beat(OP_ADD,  20'h80000, 20'h80000, 3'd1, 1'b1);
        send_beat(OP_ADD,  20'hF0000, 20'hAFFFF, 3'd1, 1'b0);
        send_beat(OP_SUB,  20'h00001, 20'h00000, 3'd1, 1'b1);
        send_beat(OP_SUB,  20'h12345, 20'h12345, 3'd1, 1'b0);
        send_beat(OP_SUB,  20'h00001, 20'h08000, 3'd1, 1'b0);
        send_beat(OP_SUB,  20'hFFFFF, 20'h7FFFF, 3'd1, 1'b1);
        send_beat(OP_RRUM, 20'h00000, 20'hABCDE, 3'd0, 1'b1);
        send_beat(OP_RRCM, 20'h00000, 20'h5A5A5, 3'd5, 1'b0);
        send_beat(OP_RRAM, 20'h00000, 20'h87654, 3'd6, 1'b1);
        send_beat(OP_RLAM, 20'h00000, 20'h13579, 3'd7, 1'b0);
        send_beat(OP_SPARE6, 20'h12345, 20'hFEDCB, 3'd2, 1'b0);
        send_beat(OP_SPARE7, 20'hFFFFF, 20'hFEDCB, 3'd3, 1'b1);

        // Random phases under different idle patterns
        for (int ph = PH_FREE; ph <= PH_PRESSURE; ph++)
        begin
            case (ph)
                PH_TX_IDLE:  begin tx_idle_pct = 69; rx_stall_pct <= 0;  end
                PH_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct <= 69; end
                PH_BOTH:     begin tx_idle_pct = 32; rx_stall_pct <= 32; end
                PH_PRESSURE:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 0;
                    rx_hold_go   <= 1'b1;
                end
                default:     begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
            endcase
            repeat (PHASE_BEATS)
                send_random_beat();
        end

        // Drain and settle
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("summary: %0d beats sent, %0d shift/rotate, %0d add/sub, %0d spare code, %0d wide",
                 n_shift + n_arith + n_spare, n_shift, n_arith, n_spare, n_wide);
        $display("summary: %0d results checked, %0d mismatches, one %0d-cycle receiver hold-off",
                 results_seen, mismatches, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
